[hw/rtl/oale_pkg.sv]
// Shared types, codes and sizes for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

	// Field widths of the request and result.
	localparam int unsigned MODE_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned IDX_W  = 5;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned CAP_W  = 6;

	// Default build sizes and the capacity register reset value.
	localparam int unsigned MAX_ENTRIES_DEF = 32;
	localparam int unsigned VALUE_BITS_DEF  = 32;
	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(32);

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIND    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_VAL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_POS = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} oale_req_t;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] entry_count;
	} oale_rsp_t;

	// What the walking pointer does in a cycle.
	typedef enum logic [1:0] {
		WALK_NONE,
		WALK_SCAN,
		WALK_UP,
		WALK_DOWN
	} oale_walk_t;

	// Where the walking pointer is loaded from.
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_POS_INC,
		PTR_HIT_INC,
		PTR_COUNT
	} oale_ptr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic          load;
		oale_ptr_sel_t ptr_sel;
		oale_walk_t    walk;
		logic          put_val;
		logic          cnt_inc;
		logic          cnt_dec;
		logic          set_res;
		logic          res_ok;
		logic          res_hit;
		logic          emit;
	} oale_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              room;
		logic              pos_le_cnt;
		logic              pos_lt_cnt;
		logic              scan_more;
		logic              up_more;
		logic              chk_pend;
		logic              hit;
		logic              wr_pend;
		logic              out_free;
	} oale_sts_t;

endpackage

[hw/rtl/oale_chan_if.sv]
// Valid/ready channel carrying one request or result payload.
`timescale 1ns / 1ps

interface oale_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/oale_datapath.sv]
// List store, walking pointer, compare and result registers of the list engine.
`timescale 1ns / 1ps

module oale_datapath #(
	parameter int unsigned MAX_ENTRIES = oale_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned VALUE_BITS  = oale_pkg::VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  oale_pkg::oale_req_t       req_payload,
	input  oale_pkg::oale_cmd_t       cmd,
	output oale_pkg::oale_sts_t       sts,
	input  logic                      cfg_we,
	input  logic [oale_pkg::CAP_W-1:0] cfg_wdata,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output oale_pkg::oale_rsp_t       rsp_payload
);
	import oale_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned PW = (POS_W > CW) ? POS_W : CW;
	localparam int unsigned KW = (CAP_W > CW) ? CAP_W : CW;

	logic [VALUE_BITS-1:0] mem [MAX_ENTRIES];

	logic [CW-1:0]         count_q;
	logic [CAP_W-1:0]      cap_q;
	logic [MODE_W-1:0]     mode_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	logic [CW-1:0]         ptr_q;
	logic                  chk_vld_q;
	logic [AW-1:0]         chk_idx_q;
	logic [AW-1:0]         hit_q;
	logic                  wr_vld_q;
	logic [AW-1:0]         wr_idx_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic                  res_ok_q;
	logic                  res_hit_q;
	logic                  out_vld_q;
	logic                  out_ok_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic [63:0]           val_w;
	logic [63:0]           hit_w;
	logic [63:0]           cnt_w;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         pos_inc;
	logic [CW-1:0]         ptr_dec;
	logic                  scan_more;
	logic                  up_more;
	logic                  hit;
	logic                  rd_en;
	logic [AW-1:0]         raddr;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [AW-1:0]         put_addr;

	// Width conversions of the value, index and count.
	assign val_w   = {32'd0, req_payload.value};
	assign hit_w   = 64'(hit_q);
	assign cnt_w   = 64'(count_q);
	assign pos_ext = PW'(pos_q);
	assign pos_inc = pos_ext + PW'(1);
	assign ptr_dec = ptr_q - CW'(1);

	// Comparisons the controller decides on.
	assign scan_more = ptr_q < count_q;
	assign up_more   = PW'(ptr_q) > pos_ext;
	assign hit       = chk_vld_q && (rdata_q == val_q);

	always_comb begin
		sts.mode       = mode_q;
		sts.room       = (KW'(count_q) < KW'(cap_q)) && (count_q < CW'(MAX_ENTRIES));
		sts.pos_le_cnt = pos_ext <= PW'(count_q);
		sts.pos_lt_cnt = pos_ext < PW'(count_q);
		sts.scan_more  = scan_more;
		sts.up_more    = up_more;
		sts.chk_pend   = chk_vld_q;
		sts.hit        = hit;
		sts.wr_pend    = wr_vld_q;
		sts.out_free   = !out_vld_q || rsp_ready;
	end

	// Read port: upward shifts read one below the pointer, the other walks at it.
	assign rd_en = (((cmd.walk == WALK_SCAN) || (cmd.walk == WALK_DOWN)) && scan_more) ||
		((cmd.walk == WALK_UP) && up_more);
	assign raddr = (cmd.walk == WALK_UP) ? ptr_dec[AW-1:0] : ptr_q[AW-1:0];

	// Write port: a pending moved entry, or the new value at its slot.
	assign put_addr = (mode_q == MODE_INSERT) ? pos_ext[AW-1:0] : count_q[AW-1:0];
	assign we       = wr_vld_q || cmd.put_val;
	assign waddr    = wr_vld_q ? wr_idx_q : put_addr;
	assign wdata    = wr_vld_q ? rdata_q : val_q;

	// List store with one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Control state: count, capacity, pipeline valids and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cap_q     <= CAP_RESET;
			chk_vld_q <= 1'b0;
			wr_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			chk_vld_q <= (cmd.walk == WALK_SCAN) && scan_more;
			wr_vld_q  <= ((cmd.walk == WALK_DOWN) && scan_more) ||
				((cmd.walk == WALK_UP) && up_more);
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Request capture, walking pointer and result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_payload.mode;
			val_q  <= val_w[VALUE_BITS-1:0];
			pos_q  <= req_payload.position;
		end
		unique case (cmd.ptr_sel)
			PTR_ZERO:    ptr_q <= '0;
			PTR_POS_INC: ptr_q <= pos_inc[CW-1:0];
			PTR_HIT_INC: ptr_q <= CW'(chk_idx_q) + CW'(1);
			PTR_COUNT:   ptr_q <= count_q;
			default: begin
				if ((cmd.walk == WALK_SCAN || cmd.walk == WALK_DOWN) && scan_more) begin
					ptr_q <= ptr_q + CW'(1);
				end else if (cmd.walk == WALK_UP && up_more) begin
					ptr_q <= ptr_dec;
				end
			end
		endcase
		if (cmd.walk == WALK_SCAN && scan_more) begin
			chk_idx_q <= ptr_q[AW-1:0];
		end
		if (hit) begin
			hit_q <= chk_idx_q;
		end
		if (cmd.walk == WALK_UP) begin
			wr_idx_q <= ptr_q[AW-1:0];
		end else if (cmd.walk == WALK_DOWN) begin
			wr_idx_q <= ptr_dec[AW-1:0];
		end
		if (cmd.set_res) begin
			res_ok_q  <= cmd.res_ok;
			res_hit_q <= cmd.res_hit;
		end
		if (cmd.emit) begin
			out_ok_q  <= res_ok_q;
			out_idx_q <= res_hit_q ? hit_w[IDX_W-1:0] : '0;
			out_cnt_q <= cnt_w[CNT_W-1:0];
		end
	end

	assign rsp_valid               = out_vld_q;
	assign rsp_payload.ok          = out_ok_q;
	assign rsp_payload.found_index = out_idx_q;
	assign rsp_payload.entry_count = out_cnt_q;

endmodule

[hw/rtl/oale_ctrl.sv]
// Controller state machine sequencing each list request.
`timescale 1ns / 1ps

module oale_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  oale_pkg::oale_sts_t sts,
	output oale_pkg::oale_cmd_t cmd
);
	import oale_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.ptr_sel = PTR_HOLD;
		cmd.walk    = WALK_NONE;
		cmd.put_val = 1'b0;
		cmd.cnt_inc = 1'b0;
		cmd.cnt_dec = 1'b0;
		cmd.set_res = 1'b0;
		cmd.res_ok  = 1'b0;
		cmd.res_hit = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.mode)
					MODE_APPEND: begin
						cmd.set_res = 1'b1;
						if (sts.room) begin
							cmd.put_val = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.res_ok  = 1'b1;
						end
						state_d = ST_DONE;
					end
					MODE_INSERT: begin
						if (sts.room && sts.pos_le_cnt) begin
							cmd.ptr_sel = PTR_COUNT;
							state_d     = ST_SHIFT_UP;
						end else begin
							cmd.set_res = 1'b1;
							state_d     = ST_DONE;
						end
					end
					MODE_FIND, MODE_DEL_VAL: begin
						cmd.ptr_sel = PTR_ZERO;
						state_d     = ST_SCAN;
					end
					MODE_DEL_POS: begin
						if (sts.pos_lt_cnt) begin
							cmd.ptr_sel = PTR_POS_INC;
							state_d     = ST_SHIFT_DN;
						end else begin
							cmd.set_res = 1'b1;
							state_d     = ST_DONE;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						state_d     = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				if (sts.hit) begin
					if (sts.mode == MODE_FIND) begin
						cmd.set_res = 1'b1;
						cmd.res_ok  = 1'b1;
						cmd.res_hit = 1'b1;
						state_d     = ST_DONE;
					end else begin
						cmd.ptr_sel = PTR_HIT_INC;
						state_d     = ST_SHIFT_DN;
					end
				end else if (!sts.scan_more && !sts.chk_pend) begin
					cmd.set_res = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.walk = WALK_SCAN;
				end
			end
			ST_SHIFT_UP: begin
				if (!sts.up_more && !sts.wr_pend) begin
					cmd.put_val = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_ok  = 1'b1;
					state_d     = ST_DONE;
				end else begin
					cmd.walk = WALK_UP;
				end
			end
			ST_SHIFT_DN: begin
				if (!sts.scan_more && !sts.wr_pend) begin
					cmd.cnt_dec = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_ok  = 1'b1;
					cmd.res_hit = (sts.mode == MODE_DEL_VAL);
					state_d     = ST_DONE;
				end else begin
					cmd.walk = WALK_DOWN;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/ordered_array_list_engine.sv]
// Append and rejected requests pass from the accepting edge through dispatch and done to
// a valid result; find walks one entry a cycle, inserts and deletes move one entry a
// cycle (delete by value scans then shifts). The single read and write port of the list
// store sets this pace. Done waits while an unaccepted result holds the output register.
// One request is in work at a time; the next is taken once its result is registered.
// Reset clears count and sets capacity to 32; stored entries stay undefined, no clearing.
`timescale 1ns / 1ps

module ordered_array_list_engine #(
	parameter int unsigned MAX_ENTRIES = oale_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned VALUE_BITS  = oale_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	oale_chan_if.sink                  req,
	oale_chan_if.source                rsp,
	input  logic                       cfg_we,
	input  logic [oale_pkg::CAP_W-1:0] cfg_wdata
);
	import oale_pkg::*;

	oale_cmd_t cmd;
	oale_sts_t sts;
	logic      req_ready;

	assign req.ready = req_ready;

	// Request sequencing.
	oale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// List store and result path.
	oale_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_payload (req.payload),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_payload (rsp.payload)
	);

`ifndef SYNTHESIS
	// The new value must never be written while a moved entry is still pending.
	a_put_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.put_val && sts.wr_pend))
		else $error("value write collides with a pending shift write");

	// A failed request reports index zero.
	a_miss_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.payload.ok) |-> (rsp.payload.found_index == '0))
		else $error("failed request carries a non-zero index");

	// Only one request is in work: ready drops after each accepted request.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in work");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the ordered array list engine, with a request driver and a result monitor.
`timescale 1ns / 1ps

module tb;
	import oale_pkg::*;

	localparam int unsigned STORE_DEPTH = MAX_ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned REPORT_LIMIT = 40;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned POOL_SIZE = 8;

	// Modes that the block treats as no operation.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	oale_chan_if #(.payload_t(oale_req_t)) req_if ();
	oale_chan_if #(.payload_t(oale_rsp_t)) rsp_if ();

	ordered_array_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted contents of the list and the capacity register.
	logic signed [DATA_W-1:0] list_store [STORE_DEPTH];
	int unsigned              held_count;
	logic [CAP_W-1:0]         capacity_reg;

	oale_rsp_t   pending_q [$];
	oale_req_t   request_q [$];
	oale_rsp_t   predicted;
	logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned failures;
	int unsigned cycle_count;

	// Remove one entry and close the gap above it.
	task automatic drop_entry(input int unsigned at);
		int unsigned i;
		for (i = at; i + 1 < held_count; i++)
			list_store[i] = list_store[i + 1];
		held_count--;
	endtask

	// Apply one request to the predicted list and work out its result.
	task automatic apply_request(input oale_req_t r, output oale_rsp_t res);
		int unsigned room;
		int unsigned hit;
		int unsigned i;
		res = '0;
		room = (capacity_reg > STORE_DEPTH) ? STORE_DEPTH : capacity_reg;
		hit = held_count;
		for (i = 0; i < held_count; i++) begin
			if (list_store[i] == r.value) begin
				hit = i;
				break;
			end
		end
		case (r.mode)
			MODE_APPEND: begin
				if (held_count < room) begin
					list_store[held_count] = r.value;
					held_count++;
					res.ok = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (held_count < room && r.position <= held_count) begin
					for (i = held_count; i > r.position; i--)
						list_store[i] = list_store[i - 1];
					list_store[r.position] = r.value;
					held_count++;
					res.ok = 1'b1;
				end
			end
			MODE_FIND: begin
				if (hit < held_count) begin
					res.ok = 1'b1;
					res.found_index = IDX_W'(hit);
				end
			end
			MODE_DEL_VAL: begin
				if (hit < held_count) begin
					drop_entry(hit);
					res.ok = 1'b1;
					res.found_index = IDX_W'(hit);
				end
			end
			MODE_DEL_POS: begin
				if (r.position < held_count) begin
					drop_entry(r.position);
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_count = CNT_W'(held_count);
	endtask

	// Compare one result with the oldest prediction.
	task automatic check_result(input oale_rsp_t got);
		oale_rsp_t want;
		bit bad;
		bad = 1'b0;
		if (pending_q.size() == 0) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: unexpected result, expected none, actual ok=%0d idx=%0d count=%0d",
					$time, got.ok, got.found_index, got.entry_count);
		end else begin
			want = pending_q.pop_front();
			if (got.ok !== want.ok) begin
				bad = 1'b1;
				if (failures < REPORT_LIMIT)
					$display("%0t: ok mismatch, expected %0d actual %0d",
						$time, want.ok, got.ok);
			end
			if (got.found_index !== want.found_index) begin
				bad = 1'b1;
				if (failures < REPORT_LIMIT)
					$display("%0t: found_index mismatch, expected %0d actual %0d",
						$time, want.found_index, got.found_index);
			end
			if (got.entry_count !== want.entry_count) begin
				bad = 1'b1;
				if (failures < REPORT_LIMIT)
					$display("%0t: entry_count mismatch, expected %0d actual %0d",
						$time, want.entry_count, got.entry_count);
			end
			if (bad)
				failures++;
		end
	endtask

	task automatic add_request(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
			input int unsigned p);
		oale_req_t r;
		r.mode = m;
		r.value = v;
		r.position = POS_W'(p);
		request_q.push_back(r);
	endtask

	// Queue random requests; values mostly come from a small pool so that finds and deletes hit.
	task automatic add_random_requests(input int unsigned n, input int unsigned pos_hi);
		int unsigned k;
		int unsigned pick;
		logic [MODE_W-1:0] m;
		logic signed [DATA_W-1:0] v;
		int unsigned p;
		for (k = 0; k < POOL_SIZE; k++)
			value_pool[k] = $urandom;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = -1;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 28)
				m = MODE_APPEND;
			else if (pick < 52)
				m = MODE_INSERT;
			else if (pick < 67)
				m = MODE_FIND;
			else if (pick < 82)
				m = MODE_DEL_VAL;
			else if (pick < 97)
				m = MODE_DEL_POS;
			else
				m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			if ($urandom_range(0, 99) < 65)
				v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				v = $urandom;
			if ($urandom_range(0, 1))
				p = $urandom_range(0, pos_hi);
			else
				p = $urandom_range(0, STORE_DEPTH - 1);
			add_request(m, v, p);
		end
	endtask

	// Wait until every queued request has been taken and every result has come back.
	task automatic wait_drained();
		@(posedge clk);
		while (request_q.size() != 0 || req_if.valid || pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = v;
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n,
			input int unsigned idle, input int unsigned stall);
		write_capacity(cap);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		add_random_requests(n, (cap > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : cap);
		wait_drained();
	endtask

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Request driver: predict at each accepted request, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.payload <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				apply_request(req_if.payload, predicted);
				pending_q.push_back(predicted);
			end
			if (!req_if.valid || req_if.ready) begin
				if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_if.valid <= 1'b1;
					req_if.payload <= request_q.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				check_result(rsp_if.payload);
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Reset, directed requests, then random phases over several capacities and idling patterns.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		rsp_if.ready = 1'b0;
		held_count = 0;
		capacity_reg = CAP_RESET;
		failures = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < STORE_DEPTH; i++)
			list_store[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list: misses and rejected positions.
		add_request(MODE_FIND, 5, 0);
		add_request(MODE_DEL_VAL, 5, 0);
		add_request(MODE_DEL_POS, 0, 0);
		add_request(MODE_INSERT, 1, 1);
		// Build a short list through every kind of insertion.
		add_request(MODE_INSERT, VAL_MAX, 0);
		add_request(MODE_APPEND, VAL_MIN, 31);
		add_request(MODE_APPEND, -1, 0);
		add_request(MODE_INSERT, 0, 3);
		add_request(MODE_INSERT, 7, 1);
		add_request(MODE_APPEND, 7, 0);
		// Duplicates: the first match wins.
		add_request(MODE_FIND, 7, 0);
		add_request(MODE_FIND, VAL_MIN, 0);
		add_request(MODE_DEL_VAL, 7, 0);
		add_request(MODE_FIND, 7, 0);
		// Positions at and beyond the count are rejected, then two in range are deleted.
		add_request(MODE_DEL_POS, 0, 5);
		add_request(MODE_DEL_POS, 0, 31);
		add_request(MODE_INSERT, 3, 31);
		add_request(MODE_DEL_POS, 0, 0);
		add_request(MODE_DEL_POS, 0, 3);
		// Unused modes change nothing.
		add_request(MODE_SPARE_LO, VAL_MAX, 31);
		add_request(MODE_W'(6), VAL_MIN, 0);
		add_request(MODE_SPARE_HI, -1, 31);
		add_request(MODE_FIND, 32'sh1234_5678, 0);
		add_request(MODE_DEL_VAL, VAL_MIN, 0);
		wait_drained();

		// Fill to the full store, then lower the capacity below the count.
		run_phase(CAP_W'(32), 300, 0, 0);
		run_phase(CAP_W'(4), 200, 70, 0);
		run_phase(CAP_W'(0), 100, 0, 70);
		run_phase(CAP_W'(63), 250, 11, 11);
		run_phase(CAP_W'(1), 100, 70, 0);
		run_phase(CAP_W'(17), 100, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/oale_pkg.sv
hw/rtl/oale_chan_if.sv
hw/rtl/oale_datapath.sv
hw/rtl/oale_ctrl.sv
hw/rtl/ordered_array_list_engine.sv
tb/tb.sv
